// File: rtl/nvmerf_pkg.sv
`default_nettype none

package nvmerf_pkg;

  // Default number of queues with a doorbell pair.
  localparam int NUM_QUEUES_DEF = 64;

  // Constant registers.
  localparam logic [63:0] CAP_VALUE  = 64'h0040_0030_1406_FFFF;
  localparam logic [63:0] VS_VALUE   = 64'h0000_0000_0002_0000;
  localparam logic [31:0] NSSR_MAGIC = 32'h4E56_4D65;

  // Register offsets.
  localparam logic [15:0] OFF_CAP    = 16'h0000;
  localparam logic [15:0] OFF_VS     = 16'h0008;
  localparam logic [15:0] OFF_INTMS  = 16'h000C;
  localparam logic [15:0] OFF_INTMC  = 16'h0010;
  localparam logic [15:0] OFF_CC     = 16'h0014;
  localparam logic [15:0] OFF_CSTS   = 16'h001C;
  localparam logic [15:0] OFF_NSSR   = 16'h0020;
  localparam logic [15:0] OFF_AQA    = 16'h0024;
  localparam logic [15:0] OFF_ASQ    = 16'h0028;
  localparam logic [15:0] OFF_ACQ    = 16'h0030;
  localparam logic [15:0] OFF_BPRSEL = 16'h0044;
  localparam logic [15:0] OFF_BPMBL  = 16'h0048;

  // Doorbell area: 8 bytes per queue, SQ tail first, CQ head at +4.
  localparam logic [16:0] DB_BASE      = 17'h0_1000;
  localparam int          DB_STRIDE    = 8;

  // Access sizes that truncate a read.
  localparam logic [3:0] SIZE_BYTE  = 4'd1;
  localparam logic [3:0] SIZE_HALF  = 4'd2;
  localparam logic [3:0] SIZE_WORD  = 4'd4;

  // Access kinds.
  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  // Reset values of the latched shifts.
  localparam logic [4:0] PAGE_SHIFT_RST = 5'd12;
  localparam logic [3:0] SQ_SHIFT_RST   = 4'd6;
  localparam logic [3:0] CQ_SHIFT_RST   = 4'd4;

  // One host access.
  typedef struct packed {
    logic        action;
    logic [15:0] offset;
    logic [63:0] write_data;
    logic [3:0]  access_size;
  } req_t;

  // One access result.
  typedef struct packed {
    logic [63:0] read_data;
    logic        ready_res;
    logic [4:0]  page_shift;
    logic [3:0]  sq_entry_shift;
    logic [3:0]  cq_entry_shift;
    logic        doorbell_valid;
    logic [5:0]  doorbell_queue;
    logic        doorbell_is_cq;
    logic [31:0] doorbell_value;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/nvmerf_req_if.sv
`default_nettype none

interface nvmerf_req_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [15:0] offset;
  logic [63:0] write_data;
  logic [3:0]  access_size;

  modport source (output valid, output action, output offset, output write_data,
                  output access_size, input ready);
  modport sink (input valid, input action, input offset, input write_data,
                input access_size, output ready);
endinterface

`default_nettype wire

// File: rtl/nvmerf_res_if.sv
`default_nettype none

interface nvmerf_res_if;
  logic        valid;
  logic        ready;
  logic [63:0] read_data;
  logic        ready_res;
  logic [4:0]  page_shift;
  logic [3:0]  sq_entry_shift;
  logic [3:0]  cq_entry_shift;
  logic        doorbell_valid;
  logic [5:0]  doorbell_queue;
  logic        doorbell_is_cq;
  logic [31:0] doorbell_value;

  modport source (output valid, output read_data, output ready_res, output page_shift,
                  output sq_entry_shift, output cq_entry_shift, output doorbell_valid,
                  output doorbell_queue, output doorbell_is_cq, output doorbell_value,
                  input ready);
  modport sink (input valid, input read_data, input ready_res, input page_shift,
                input sq_entry_shift, input cq_entry_shift, input doorbell_valid,
                input doorbell_queue, input doorbell_is_cq, input doorbell_value,
                output ready);
endinterface

`default_nettype wire

// File: rtl/nvmerf_regs.sv
`default_nettype none

module nvmerf_regs #(
  parameter int NUM_QUEUES = nvmerf_pkg::NUM_QUEUES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              commit,
  input  wire nvmerf_pkg::req_t  req,
  output nvmerf_pkg::res_t       res
);
  import nvmerf_pkg::*;

  // First offset past the last queue's doorbell slot.
  localparam logic [16:0] DB_END = DB_BASE + 17'(NUM_QUEUES * DB_STRIDE);

  // Architectural registers. CSTS.RDY always equals the enable flag, CC bit 0,
  // but is kept in its own bit.
  logic [31:0] interrupt_mask, interrupt_mask_next;
  logic [31:0] controller_config, controller_config_next;
  logic        ready_bit, ready_bit_next;
  logic [31:0] admin_queue_attrs, admin_queue_attrs_next;
  logic [63:0] admin_sq_base, admin_sq_base_next;
  logic [63:0] admin_cq_base, admin_cq_base_next;
  logic [31:0] boot_part_select, boot_part_select_next;
  logic [63:0] boot_part_buffer, boot_part_buffer_next;
  logic [4:0]  page_shift_reg, page_shift_next;
  logic [3:0]  sq_shift_reg, sq_shift_next;
  logic [3:0]  cq_shift_reg, cq_shift_next;

  logic        is_write;
  logic        in_regs;
  logic        in_db;
  logic [15:0] db_rel;
  logic [31:0] d32;
  logic        half_only;
  logic [63:0] rd_raw;
  logic [63:0] rd_masked;

  // Offset classification.
  always_comb begin
    is_write  = (req.action == ACT_WRITE);
    in_regs   = ({1'b0, req.offset} < DB_BASE);
    in_db     = !in_regs && ({1'b0, req.offset} < DB_END);
    db_rel    = req.offset - DB_BASE[15:0];
    d32       = req.write_data[31:0];
    half_only = (req.access_size == SIZE_WORD);
  end

  // Register read mux.
  always_comb begin
    case (req.offset)
      OFF_CAP:    rd_raw = CAP_VALUE;
      OFF_VS:     rd_raw = VS_VALUE;
      OFF_INTMS:  rd_raw = {32'd0, interrupt_mask};
      OFF_INTMC:  rd_raw = {32'd0, interrupt_mask};
      OFF_CC:     rd_raw = {32'd0, controller_config};
      OFF_CSTS:   rd_raw = {63'd0, ready_bit};
      OFF_AQA:    rd_raw = {32'd0, admin_queue_attrs};
      OFF_ASQ:    rd_raw = admin_sq_base;
      OFF_ACQ:    rd_raw = admin_cq_base;
      OFF_BPRSEL: rd_raw = {32'd0, boot_part_select};
      OFF_BPMBL:  rd_raw = boot_part_buffer;
      default:    rd_raw = 64'd0;
    endcase
  end

  // Truncate the read to the access size; other sizes return all bits.
  always_comb begin
    case (req.access_size)
      SIZE_BYTE: rd_masked = {56'd0, rd_raw[7:0]};
      SIZE_HALF: rd_masked = {48'd0, rd_raw[15:0]};
      SIZE_WORD: rd_masked = {32'd0, rd_raw[31:0]};
      default:   rd_masked = rd_raw;
    endcase
  end

  // Register writes, controller enable handling and subsystem reset.
  always_comb begin
    interrupt_mask_next    = interrupt_mask;
    controller_config_next = controller_config;
    ready_bit_next         = ready_bit;
    admin_queue_attrs_next = admin_queue_attrs;
    admin_sq_base_next     = admin_sq_base;
    admin_cq_base_next     = admin_cq_base;
    boot_part_select_next  = boot_part_select;
    boot_part_buffer_next  = boot_part_buffer;
    page_shift_next        = page_shift_reg;
    sq_shift_next          = sq_shift_reg;
    cq_shift_next          = cq_shift_reg;
    if (is_write && in_regs) begin
      case (req.offset)
        OFF_INTMS: interrupt_mask_next = interrupt_mask | d32;
        OFF_INTMC: interrupt_mask_next = interrupt_mask & ~d32;
        OFF_CC: begin
          controller_config_next = d32;
          if (!controller_config[0] && d32[0]) begin
            page_shift_next = PAGE_SHIFT_RST + {1'b0, d32[10:7]};
            sq_shift_next   = d32[19:16];
            cq_shift_next   = d32[23:20];
            ready_bit_next  = 1'b1;
          end else if (controller_config[0] && !d32[0]) begin
            ready_bit_next  = 1'b0;
          end
        end
        OFF_NSSR: begin
          // Subsystem reset: registers back to defaults, shifts kept.
          if (d32 == NSSR_MAGIC) begin
            interrupt_mask_next    = '0;
            controller_config_next = '0;
            ready_bit_next         = 1'b0;
            admin_queue_attrs_next = '0;
            admin_sq_base_next     = '0;
            admin_cq_base_next     = '0;
            boot_part_select_next  = '0;
            boot_part_buffer_next  = '0;
          end
        end
        OFF_AQA:    admin_queue_attrs_next = d32;
        OFF_ASQ:    admin_sq_base_next = half_only ? {admin_sq_base[63:32], d32}
                                                   : req.write_data;
        OFF_ACQ:    admin_cq_base_next = half_only ? {admin_cq_base[63:32], d32}
                                                   : req.write_data;
        OFF_BPRSEL: boot_part_select_next = d32;
        OFF_BPMBL:  boot_part_buffer_next = half_only ? {boot_part_buffer[63:32], d32}
                                                      : req.write_data;
        default: ;
      endcase
    end
  end

  // Result of the access. Doorbell values are handed on with the result;
  // nothing in the block reads them back, so they are not kept here.
  always_comb begin
    res.read_data      = (!is_write && in_regs) ? rd_masked : 64'd0;
    res.ready_res      = ready_bit_next;
    res.page_shift     = page_shift_next;
    res.sq_entry_shift = sq_shift_next;
    res.cq_entry_shift = cq_shift_next;
    res.doorbell_valid = is_write && in_db && (db_rel[1:0] == 2'b00);
    res.doorbell_queue = res.doorbell_valid ? db_rel[8:3] : 6'd0;
    res.doorbell_is_cq = res.doorbell_valid ? db_rel[2] : 1'b0;
    res.doorbell_value = res.doorbell_valid ? d32 : 32'd0;
  end

  // State update when the access leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      interrupt_mask    <= '0;
      controller_config <= '0;
      ready_bit         <= 1'b0;
      admin_queue_attrs <= '0;
      admin_sq_base     <= '0;
      admin_cq_base     <= '0;
      boot_part_select  <= '0;
      boot_part_buffer  <= '0;
      page_shift_reg    <= PAGE_SHIFT_RST;
      sq_shift_reg      <= SQ_SHIFT_RST;
      cq_shift_reg      <= CQ_SHIFT_RST;
    end else if (commit) begin
      interrupt_mask    <= interrupt_mask_next;
      controller_config <= controller_config_next;
      ready_bit         <= ready_bit_next;
      admin_queue_attrs <= admin_queue_attrs_next;
      admin_sq_base     <= admin_sq_base_next;
      admin_cq_base     <= admin_cq_base_next;
      boot_part_select  <= boot_part_select_next;
      boot_part_buffer  <= boot_part_buffer_next;
      page_shift_reg    <= page_shift_next;
      sq_shift_reg      <= sq_shift_next;
      cq_shift_reg      <= cq_shift_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/nvme_controller_register_file_unit.sv
`default_nettype none

// Controller register file for the BAR0 space of an NVMe controller. Each
// request is one host read or write at a byte offset, and each request gives
// exactly one result: the read data truncated to the access size (0 on
// writes), CSTS.RDY and the latched page and entry shifts after the access,
// and a doorbell report when the access wrote an SQ-tail or CQ-head doorbell.
// A new request is accepted in every cycle while the result register is not
// stalled; each result passes the input register and the result register,
// around the single decode and update step. A stalled result register still
// lets a request wait in the input register. Doorbell values are reported and
// not stored; doorbell reads return 0.
module nvme_controller_register_file_unit #(
  parameter int NUM_QUEUES = nvmerf_pkg::NUM_QUEUES_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  nvmerf_req_if.sink    req,
  nvmerf_res_if.source  res
);
  import nvmerf_pkg::*;

  logic  in_valid;
  req_t  in_req;
  logic  out_valid;
  res_t  out_res;
  res_t  step_res;
  logic  advance;

  // Input request moves on when the result register is free or draining.
  assign advance   = in_valid && (!out_valid || res.ready);
  assign req.ready = !in_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      in_req <= '{action: req.action, offset: req.offset,
                  write_data: req.write_data, access_size: req.access_size};
    end
  end

  // Decode, register update and result forming.
  nvmerf_regs #(
    .NUM_QUEUES (NUM_QUEUES)
  ) u_regs (
    .clk    (clk),
    .rst    (rst),
    .commit (advance),
    .req    (in_req),
    .res    (step_res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign res.valid          = out_valid;
  assign res.read_data      = out_res.read_data;
  assign res.ready_res      = out_res.ready_res;
  assign res.page_shift     = out_res.page_shift;
  assign res.sq_entry_shift = out_res.sq_entry_shift;
  assign res.cq_entry_shift = out_res.cq_entry_shift;
  assign res.doorbell_valid = out_res.doorbell_valid;
  assign res.doorbell_queue = out_res.doorbell_queue;
  assign res.doorbell_is_cq = out_res.doorbell_is_cq;
  assign res.doorbell_value = out_res.doorbell_value;

endmodule

`default_nettype wire

// File: test/nvmerf_scoreboard_pkg.sv
package nvmerf_scoreboard_pkg;

  import nvmerf_pkg::*;

  // Shadow of the BAR0 register file. Every accepted request updates the
  // shadow registers and queues the result the block must return for it.
  class bar0_scoreboard;

    localparam logic [16:0] DB_END = DB_BASE + 17'(NUM_QUEUES_DEF * DB_STRIDE);

    logic [31:0] intr_mask;
    logic [31:0] ctrl_cfg;
    logic        csts_rdy;
    logic [31:0] aqa_reg;
    logic [63:0] asq_reg;
    logic [63:0] acq_reg;
    logic [31:0] bprsel_reg;
    logic [63:0] bpmbl_reg;
    logic [4:0]  page_shift_q;
    logic [3:0]  sq_shift_q;
    logic [3:0]  cq_shift_q;

    res_t access_results[$];
    int   errors;
    int   shown;

    function new();
      clear_registers();
      page_shift_q = PAGE_SHIFT_RST;
      sq_shift_q = SQ_SHIFT_RST;
      cq_shift_q = CQ_SHIFT_RST;
      errors = 0;
      shown = 0;
    endfunction

    // Register defaults, shared by reset and a subsystem reset. The latched
    // shifts survive a subsystem reset.
    function void clear_registers();
      intr_mask = '0;
      ctrl_cfg = '0;
      csts_rdy = 1'b0;
      aqa_reg = '0;
      asq_reg = '0;
      acq_reg = '0;
      bprsel_reg = '0;
      bpmbl_reg = '0;
    endfunction

    // A 64-bit register takes only its low half on a 4-byte write.
    function logic [63:0] merge_write(logic [63:0] old, logic [63:0] data, logic [3:0] size);
      if (size == SIZE_WORD) return {old[63:32], data[31:0]};
      return data;
    endfunction

    function logic [63:0] register_value(logic [15:0] off);
      case (off)
        OFF_CAP: return CAP_VALUE;
        OFF_VS: return VS_VALUE;
        OFF_INTMS, OFF_INTMC: return {32'b0, intr_mask};
        OFF_CC: return {32'b0, ctrl_cfg};
        OFF_CSTS: return {63'b0, csts_rdy};
        OFF_AQA: return {32'b0, aqa_reg};
        OFF_ASQ: return asq_reg;
        OFF_ACQ: return acq_reg;
        OFF_BPRSEL: return {32'b0, bprsel_reg};
        OFF_BPMBL: return bpmbl_reg;
        default: return '0;
      endcase
    endfunction

    // Enabling latches the shifts of the new value; disabling drops RDY.
    function void write_cc(logic [31:0] nv);
      if (!ctrl_cfg[0] && nv[0]) begin
        page_shift_q = 5'd12 + {1'b0, nv[10:7]};
        sq_shift_q = nv[19:16];
        cq_shift_q = nv[23:20];
        csts_rdy = 1'b1;
      end else if (ctrl_cfg[0] && !nv[0]) begin
        csts_rdy = 1'b0;
      end
      ctrl_cfg = nv;
    endfunction

    // Apply one accepted request and queue the result it must produce.
    function void note_access(req_t r);
      res_t        want;
      logic [31:0] d32;
      logic [15:0] rel;
      logic [16:0] off17;

      want = '0;
      d32 = r.write_data[31:0];
      off17 = {1'b0, r.offset};
      if (r.action == ACT_READ) begin
        if (off17 < DB_BASE) begin
          want.read_data = register_value(r.offset);
          if (r.access_size == SIZE_BYTE) want.read_data[63:8] = '0;
          else if (r.access_size == SIZE_HALF) want.read_data[63:16] = '0;
          else if (r.access_size == SIZE_WORD) want.read_data[63:32] = '0;
        end
      end else if (off17 < DB_BASE) begin
        case (r.offset)
          OFF_INTMS: intr_mask = intr_mask | d32;
          OFF_INTMC: intr_mask = intr_mask & ~d32;
          OFF_CC: write_cc(d32);
          OFF_NSSR: if (d32 == NSSR_MAGIC) clear_registers();
          OFF_AQA: aqa_reg = d32;
          OFF_ASQ: asq_reg = merge_write(asq_reg, r.write_data, r.access_size);
          OFF_ACQ: acq_reg = merge_write(acq_reg, r.write_data, r.access_size);
          OFF_BPRSEL: bprsel_reg = d32;
          OFF_BPMBL: bpmbl_reg = merge_write(bpmbl_reg, r.write_data, r.access_size);
          default: ;
        endcase
      end else if (off17 < DB_END) begin
        // Only the SQ-tail and CQ-head words of a slot are doorbells.
        rel = r.offset - DB_BASE[15:0];
        if (rel[2:0] == 3'd0 || rel[2:0] == 3'd4) begin
          want.doorbell_valid = 1'b1;
          want.doorbell_queue = rel[8:3];
          want.doorbell_is_cq = rel[2];
          want.doorbell_value = d32;
        end
      end
      want.ready_res = csts_rdy;
      want.page_shift = page_shift_q;
      want.sq_entry_shift = sq_shift_q;
      want.cq_entry_shift = cq_shift_q;
      access_results.push_back(want);
    endfunction

    function bit field_ok(string name, logic [63:0] want, logic [63:0] got);
      if (want === got) return 1'b1;
      if (shown < 10) $display("mismatch in %s: expected %h, actual %h", name, want, got);
      return 1'b0;
    endfunction

    // Compare one returned result with the oldest outstanding one.
    function void check_access_result(res_t got);
      res_t want;
      bit   ok;

      if (access_results.size() == 0) begin
        if (shown < 10) $display("result with no request outstanding: %h", got);
        errors++;
        shown++;
        return;
      end
      want = access_results.pop_front();
      ok = 1'b1;
      ok &= field_ok("read_data", want.read_data, got.read_data);
      ok &= field_ok("ready_res", 64'(want.ready_res), 64'(got.ready_res));
      ok &= field_ok("page_shift", 64'(want.page_shift), 64'(got.page_shift));
      ok &= field_ok("sq_entry_shift", 64'(want.sq_entry_shift), 64'(got.sq_entry_shift));
      ok &= field_ok("cq_entry_shift", 64'(want.cq_entry_shift), 64'(got.cq_entry_shift));
      ok &= field_ok("doorbell_valid", 64'(want.doorbell_valid), 64'(got.doorbell_valid));
      ok &= field_ok("doorbell_queue", 64'(want.doorbell_queue), 64'(got.doorbell_queue));
      ok &= field_ok("doorbell_is_cq", 64'(want.doorbell_is_cq), 64'(got.doorbell_is_cq));
      ok &= field_ok("doorbell_value", 64'(want.doorbell_value), 64'(got.doorbell_value));
      if (!ok) begin
        errors++;
        shown++;
      end
    endfunction

    function int outstanding();
      return access_results.size();
    endfunction

    function bit failed();
      return errors != 0 || access_results.size() != 0;
    endfunction

  endclass

endpackage

// File: test/nvme_controller_register_file_unit_tb.sv
module nvme_controller_register_file_unit_tb;

  import nvmerf_pkg::*;
  import nvmerf_scoreboard_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_STALL = 300;
  localparam int PHASE_ITEMS = 400;

  logic clk;
  logic rst;
  int   cycles;
  bit   no_idle;
  bit   hold_results;

  bar0_scoreboard sb;

  nvmerf_req_if req_ch ();
  nvmerf_res_if res_ch ();

  nvme_controller_register_file_unit dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .res(res_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Watch both channels; a request is noted before a result is checked.
  always @(posedge clk) begin
    req_t seen_req;
    res_t seen_res;
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        seen_req.action = req_ch.action;
        seen_req.offset = req_ch.offset;
        seen_req.write_data = req_ch.write_data;
        seen_req.access_size = req_ch.access_size;
        sb.note_access(seen_req);
      end
      if (res_ch.valid && res_ch.ready) begin
        seen_res.read_data = res_ch.read_data;
        seen_res.ready_res = res_ch.ready_res;
        seen_res.page_shift = res_ch.page_shift;
        seen_res.sq_entry_shift = res_ch.sq_entry_shift;
        seen_res.cq_entry_shift = res_ch.cq_entry_shift;
        seen_res.doorbell_valid = res_ch.doorbell_valid;
        seen_res.doorbell_queue = res_ch.doorbell_queue;
        seen_res.doorbell_is_cq = res_ch.doorbell_is_cq;
        seen_res.doorbell_value = res_ch.doorbell_value;
        sb.check_access_result(seen_res);
      end
    end
  end

  // Result side: a random wait before each result, and one long hold-off.
  initial begin
    int gap;
    res_ch.ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_results) begin
        res_ch.ready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
        hold_results = 1'b0;
      end
      gap = no_idle ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
    end
  end

  function automatic req_t access(logic act, logic [15:0] off, logic [63:0] data,
                                  logic [3:0] size);
    req_t r;
    r.action = act;
    r.offset = off;
    r.write_data = data;
    r.access_size = size;
    return r;
  endfunction

  function automatic logic [15:0] random_register_offset();
    case ($urandom_range(0, 19))
      0: return OFF_CAP;
      1: return OFF_VS;
      2: return OFF_INTMS;
      3: return OFF_INTMC;
      4, 5: return OFF_CC;
      6: return OFF_CSTS;
      7: return OFF_NSSR;
      8: return OFF_AQA;
      9: return OFF_ASQ;
      10: return OFF_ACQ;
      11: return OFF_BPRSEL;
      12: return OFF_BPMBL;
      13: return OFF_ASQ + 16'd4;
      14: return OFF_ACQ + 16'd4;
      15: return OFF_BPMBL + 16'd4;
      16: return 16'h0038;
      17: return 16'h003C;
      18: return 16'h0040;
      default: return 16'($urandom_range(0, 16'h0FFF));
    endcase
  endfunction

  // Mostly known registers and doorbell slots, with some raw offsets.
  function automatic req_t random_request();
    req_t        r;
    int          pick;
    logic [15:0] slot;
    pick = $urandom_range(0, 99);
    r.action = 1'($urandom_range(0, 1));
    r.write_data = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: r.access_size = 4'($urandom_range(0, 15));
      1, 2: r.access_size = SIZE_BYTE;
      3, 4: r.access_size = SIZE_HALF;
      5, 6: r.access_size = SIZE_WORD;
      default: r.access_size = 4'd8;
    endcase
    if (pick < 55) begin
      r.offset = random_register_offset();
      if (r.offset == OFF_NSSR && $urandom_range(0, 5) == 0)
        r.write_data[31:0] = NSSR_MAGIC;
    end else if (pick < 88) begin
      slot = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 7))
                                         : 16'($urandom_range(0, 1) * 4);
      r.offset = DB_BASE[15:0] + 16'($urandom_range(0, 64)) * 16'(DB_STRIDE) + slot;
      if ($urandom_range(0, 3) != 0) r.action = ACT_WRITE;
    end else begin
      r.offset = 16'($urandom);
    end
    return r;
  endfunction

  // Offer one request, after a random gap, and hold it until it is taken.
  task automatic send_request(input req_t r);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.action <= r.action;
    req_ch.offset <= r.offset;
    req_ch.write_data <= r.write_data;
    req_ch.access_size <= r.access_size;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Stop offering and wait until every outstanding result has come back.
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
  endtask

  initial begin
    sb = new();
    cycles = 0;
    no_idle = 1'b0;
    hold_results = 1'b0;
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.action <= ACT_READ;
    req_ch.offset <= '0;
    req_ch.write_data <= '0;
    req_ch.access_size <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: constants at every size, mask set and clear, enable and
    // disable, half writes, subsystem reset and the doorbell corners.
    send_request(access(ACT_READ, OFF_CAP, '0, 4'd8));
    send_request(access(ACT_READ, OFF_CAP, '0, SIZE_BYTE));
    send_request(access(ACT_READ, OFF_CAP, '0, SIZE_HALF));
    send_request(access(ACT_READ, OFF_CAP, '0, SIZE_WORD));
    send_request(access(ACT_READ, OFF_VS, '0, 4'd0));
    send_request(access(ACT_WRITE, OFF_INTMS, '1, SIZE_WORD));
    send_request(access(ACT_READ, OFF_INTMC, '0, SIZE_WORD));
    send_request(access(ACT_WRITE, OFF_INTMC, 64'h0000_0000_0000_FFFF, SIZE_WORD));
    send_request(access(ACT_READ, OFF_INTMS, '0, 4'd15));
    send_request(access(ACT_WRITE, OFF_CC, 64'hFFFF_FFFF_00FF_0781, SIZE_WORD));
    send_request(access(ACT_READ, OFF_CSTS, '0, SIZE_WORD));
    send_request(access(ACT_WRITE, OFF_CC, 64'h0000_0000_00FF_0780, SIZE_WORD));
    send_request(access(ACT_WRITE, OFF_CC, 64'h0000_0000_0000_0001, 4'd8));
    send_request(access(ACT_WRITE, OFF_ASQ, '1, 4'd8));
    send_request(access(ACT_WRITE, OFF_ASQ, '0, SIZE_WORD));
    send_request(access(ACT_WRITE, OFF_ASQ + 16'd4, '0, SIZE_WORD));
    send_request(access(ACT_READ, OFF_ASQ, '0, 4'd8));
    send_request(access(ACT_WRITE, OFF_ACQ, '1, SIZE_HALF));
    send_request(access(ACT_WRITE, OFF_BPMBL, '1, SIZE_WORD));
    send_request(access(ACT_WRITE, OFF_NSSR, 64'h0000_0000_4E56_4D64, SIZE_WORD));
    send_request(access(ACT_WRITE, OFF_CAP, '0, 4'd8));
    send_request(access(ACT_WRITE, OFF_NSSR, {32'hFFFF_FFFF, NSSR_MAGIC}, SIZE_WORD));
    send_request(access(ACT_WRITE, DB_BASE[15:0], 64'hFFFF_FFFF_FFFF_FFFF, SIZE_WORD));
    send_request(access(ACT_WRITE, 16'h11FC, 64'h0000_0000_1234_5678, SIZE_WORD));
    send_request(access(ACT_WRITE, 16'h1002, '1, SIZE_WORD));
    send_request(access(ACT_WRITE, 16'h1200, '1, SIZE_WORD));
    send_request(access(ACT_READ, DB_BASE[15:0], '0, SIZE_WORD));
    send_request(access(ACT_READ, 16'hFFFF, '0, 4'd8));
    drain_results();

    // Random phases: normal idling, back to back, a long result stall,
    // then normal idling again, each drained before the next.
    for (int phase = 0; phase < 4; phase++) begin
      no_idle = (phase == 1);
      if (phase == 2) hold_results = 1'b1;
      repeat (PHASE_ITEMS) send_request(random_request());
      drain_results();
    end
    no_idle = 1'b0;

    // Idle on to catch any stray result.
    repeat (20) @(posedge clk);
    if (!sb.failed()) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: nvme_controller_register_file_unit.f
rtl/nvmerf_pkg.sv
rtl/nvmerf_req_if.sv
rtl/nvmerf_res_if.sv
rtl/nvmerf_regs.sv
rtl/nvme_controller_register_file_unit.sv
test/nvmerf_scoreboard_pkg.sv
test/nvme_controller_register_file_unit_tb.sv
